### rtl/ocmvp_pkg.sv
// Types, constants and arithmetic helpers for the orbit camera MVP matrix block.
// Used by orbit_camera_mvp_matrix; depends on nothing else.
package ocmvp_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_ASPECT = 2'd0;
	localparam logic [1:0] REG_BOX    = 2'd1;

	// Angle constants, Q16.16
	localparam logic signed [20:0] PI_Q16      = 21'sd205887;
	localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;
	localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
	localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;

	// Projection constants, Q16.16
	localparam logic signed [31:0] COT_HALF_FOV = 32'sd155007;
	localparam logic signed [31:0] PROJ_A       = -32'sd66860;
	localparam logic signed [47:0] PROJ_B       = -48'sd133720;

	// cot(0.4) * 4096 in Q16.16, the dividend of the aspect division
	localparam logic [29:0] FA_DIVIDEND = 30'd634908672;
	localparam logic [29:0] FA_RESET    = 30'd155007;
	localparam int unsigned DIV_STEPS   = 30;

	localparam logic signed [20:0] ATAN_TAB [16] = '{
		21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150, 21'sd4091, 21'sd2047,
		21'sd1024, 21'sd512, 21'sd256, 21'sd128, 21'sd64, 21'sd32,
		21'sd16, 21'sd8, 21'sd4, 21'sd2
	};

	typedef struct packed {
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [20:0] z;
		logic               flip;
	} cordic_t;

	// Bring a Q4.12 angle into [-pi/2, pi/2] and seed the rotation
	function automatic cordic_t cordic_init(logic signed [15:0] ang);
		cordic_t c;
		logic signed [20:0] z;
		z = {ang[15], ang, 4'b0000};
		if (z > PI_Q16) begin
			z = z - TWO_PI_Q16;
		end else if (z < -PI_Q16) begin
			z = z + TWO_PI_Q16;
		end
		c.flip = 1'b0;
		if (z > HALF_PI_Q16) begin
			z = z - PI_Q16;
			c.flip = 1'b1;
		end else if (z < -HALF_PI_Q16) begin
			z = z + PI_Q16;
			c.flip = 1'b1;
		end
		c.x = CORDIC_GAIN;
		c.y = '0;
		c.z = z;
		return c;
	endfunction

	// Four rotation steps starting at step index base
	function automatic cordic_t cordic4(cordic_t c, logic [3:0] base);
		cordic_t r;
		logic signed [19:0] x;
		logic signed [19:0] y;
		logic signed [19:0] nx;
		logic signed [20:0] z;
		logic [3:0] i;
		x = c.x;
		y = c.y;
		z = c.z;
		for (int k = 0; k < 4; k++) begin
			i = base + 4'(k);
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z  = z - ATAN_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z  = z + ATAN_TAB[i];
			end
			x = nx;
		end
		r.x = x;
		r.y = y;
		r.z = z;
		r.flip = c.flip;
		return r;
	endfunction

	// Q16.16 product rounded half up
	function automatic logic signed [47:0] mulq(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		p = p + 64'sd32768;
		return p[63:16];
	endfunction

	// Saturate to signed 32 bits
	function automatic logic [31:0] sat32(logic signed [47:0] v);
		logic [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -48'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/orbit_camera_mvp_matrix.sv
// Orbit camera model-view-projection block: trig, look-at view, projection.
// Depends on ocmvp_pkg for constants, CORDIC steps and Q16.16 helpers.
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | azimuth, elevation, distance
// out     | output    | out_valid/out_stall| column_index, row0..3_value, cam_x/y/z, last_column
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Ten register stages (range reduction, four CORDIC stages of four steps, the
// half-turn fold, three product stages, projection) feed a column register that
// emits four results per item, one column at a time, and loads the next item
// as the last column of the current one leaves. A write to aspect_ratio starts
// a bit-serial division, during which in_stall is high. After reset the factor
// is ready at once. out_stall holds the current column and, once the pipeline
// backs up, raises in_stall.
module orbit_camera_mvp_matrix
	import ocmvp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] azimuth,
	input  logic signed [15:0] elevation,
	input  logic [15:0]        distance,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         column_index,
	output logic signed [31:0] row0_value,
	output logic signed [31:0] row1_value,
	output logic signed [31:0] row2_value,
	output logic signed [31:0] row3_value,
	output logic signed [31:0] cam_x,
	output logic signed [31:0] cam_y,
	output logic signed [31:0] cam_z,
	output logic               last_column
);

	// Configuration and the aspect divider
	logic [15:0] box_q;
	logic [15:0] div_den_q;
	logic [15:0] div_rem_q;
	logic [29:0] div_quo_q;
	logic [4:0]  div_cnt_q;
	logic        div_busy_q;
	logic [16:0] div_trial;
	logic        div_ge;
	logic [15:0] den_new;

	assign den_new   = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
	assign div_trial = {div_rem_q, div_quo_q[29]};
	assign div_ge    = div_trial >= {1'b0, div_den_q};

	// Restart the division on an aspect write; else store a box write and, while busy, shift one quotient bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q      <= 16'd16384;
			div_den_q  <= 16'd4096;
			div_rem_q  <= '0;
			div_quo_q  <= FA_RESET;
			div_cnt_q  <= '0;
			div_busy_q <= 1'b0;
		end else if (cfg_we && cfg_index == REG_ASPECT) begin
			div_den_q  <= den_new;
			div_rem_q  <= '0;
			div_quo_q  <= FA_DIVIDEND + 30'(den_new >> 1);
			div_cnt_q  <= '0;
			div_busy_q <= 1'b1;
		end else begin
			if (cfg_we && cfg_index == REG_BOX) begin
				box_q <= cfg_data;
			end
			if (div_busy_q) begin
				div_rem_q <= div_ge ? 16'(div_trial - {1'b0, div_den_q}) : div_trial[15:0];
				div_quo_q <= {div_quo_q[28:0], div_ge};
				div_cnt_q <= div_cnt_q + 5'd1;
				if (div_cnt_q == 5'(DIV_STEPS - 1)) begin
					div_busy_q <= 1'b0;
				end
			end
		end
	end

	// Pipeline control
	logic [10:1] vld_q;
	logic        en;
	logic        acc;
	logic        ser_free;
	logic        ser_valid_q;
	logic [1:0]  ser_col_q;

	assign ser_free = !ser_valid_q || (ser_col_q == 2'd3 && !out_stall);
	assign en       = !(vld_q[10] && !ser_free);
	assign in_stall = !en || div_busy_q;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[9:1], acc};
		end
	end

	// Shared operands from configuration
	logic signed [31:0] half;
	logic signed [31:0] fa;
	assign half = {9'b0, box_q, 7'b0};
	assign fa   = {2'b0, div_quo_q};

	// Stages 1 to 5: range reduction and CORDIC
	cordic_t az_s1, az_s2, az_s3, az_s4, az_s5;
	cordic_t el_s1, el_s2, el_s3, el_s4, el_s5;
	logic [15:0] dist_s1, dist_s2, dist_s3, dist_s4, dist_s5, dist_s6, dist_s7, dist_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			az_s1 <= cordic_init(azimuth);
			el_s1 <= cordic_init(elevation);
			az_s2 <= cordic4(az_s1, 4'd0);
			el_s2 <= cordic4(el_s1, 4'd0);
			az_s3 <= cordic4(az_s2, 4'd4);
			el_s3 <= cordic4(el_s2, 4'd4);
			az_s4 <= cordic4(az_s3, 4'd8);
			el_s4 <= cordic4(el_s3, 4'd8);
			az_s5 <= cordic4(az_s4, 4'd12);
			el_s5 <= cordic4(el_s4, 4'd12);
			dist_s1 <= distance;
			dist_s2 <= dist_s1;
			dist_s3 <= dist_s2;
			dist_s4 <= dist_s3;
			dist_s5 <= dist_s4;
			dist_s6 <= dist_s5;
			dist_s7 <= dist_s6;
			dist_s8 <= dist_s7;
		end
	end

	// Stage 6: undo the half-turn fold
	logic signed [19:0] cax_s6, sax_s6, cel_s6, sel_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			cax_s6 <= az_s5.flip ? -az_s5.x : az_s5.x;
			sax_s6 <= az_s5.flip ? -az_s5.y : az_s5.y;
			cel_s6 <= el_s5.flip ? -el_s5.x : el_s5.x;
			sel_s6 <= el_s5.flip ? -el_s5.y : el_s5.y;
		end
	end

	// Stage 7: first products
	logic signed [31:0] dist32_s6, dist32_s8;
	logic signed [31:0] dc_s7, dzc_s7, dx_s7, dy_s7, ux_s7, uy_s7;
	logic signed [19:0] cax_s7, sax_s7, cel_s7, sel_s7;
	assign dist32_s6 = {8'b0, dist_s6, 8'b0};
	always_ff @(posedge clk) begin
		if (en) begin
			dc_s7  <= 32'(mulq(dist32_s6, 32'(cel_s6)));
			dzc_s7 <= 32'(mulq(dist32_s6, 32'(sel_s6)));
			dx_s7  <= 32'(mulq(32'(cel_s6), 32'(cax_s6)));
			dy_s7  <= 32'(mulq(32'(cel_s6), 32'(sax_s6)));
			ux_s7  <= 32'(-mulq(32'(sel_s6), 32'(cax_s6)));
			uy_s7  <= 32'(-mulq(32'(sel_s6), 32'(sax_s6)));
			cax_s7 <= cax_s6;
			sax_s7 <= sax_s6;
			cel_s7 <= cel_s6;
			sel_s7 <= sel_s6;
		end
	end

	// Stage 8: camera position, right translation, dot product sums
	logic signed [31:0] cx_s8, cy_s8, cz_s8, v03_s8, sum1_s8, sum2_s8;
	logic signed [31:0] ux_s8, uy_s8, dx_s8, dy_s8;
	logic signed [19:0] cax_s8, sax_s8, cel_s8, sel_s8;
	logic signed [31:0] diff_s7;
	assign diff_s7 = 32'(cax_s7) - 32'(sax_s7);
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s8   <= 32'(half + mulq(dc_s7, 32'(cax_s7)));
			cy_s8   <= 32'(half + mulq(dc_s7, 32'(sax_s7)));
			cz_s8   <= half + dzc_s7;
			v03_s8  <= 32'(-mulq(half, diff_s7));
			sum1_s8 <= ux_s7 + uy_s7 + 32'(cel_s7);
			sum2_s8 <= dx_s7 + dy_s7 + 32'(sel_s7);
			ux_s8   <= ux_s7;
			uy_s8   <= uy_s7;
			dx_s8   <= dx_s7;
			dy_s8   <= dy_s7;
			cax_s8  <= cax_s7;
			sax_s8  <= sax_s7;
			cel_s8  <= cel_s7;
			sel_s8  <= sel_s7;
		end
	end

	// Stage 9: up and forward translations
	logic signed [31:0] v13_s9, v23_s9, cx_s9, cy_s9, cz_s9, v03_s9;
	logic signed [31:0] ux_s9, uy_s9, dx_s9, dy_s9;
	logic signed [19:0] cax_s9, sax_s9, cel_s9, sel_s9;
	logic signed [47:0] m23_s8;
	assign dist32_s8 = {8'b0, dist_s8, 8'b0};
	assign m23_s8    = mulq(half, sum2_s8);
	always_ff @(posedge clk) begin
		if (en) begin
			v13_s9 <= 32'(-mulq(half, sum1_s8));
			v23_s9 <= 32'(-(m23_s8 + dist32_s8));
			cx_s9  <= cx_s8;
			cy_s9  <= cy_s8;
			cz_s9  <= cz_s8;
			v03_s9 <= v03_s8;
			ux_s9  <= ux_s8;
			uy_s9  <= uy_s8;
			dx_s9  <= dx_s8;
			dy_s9  <= dy_s8;
			cax_s9 <= cax_s8;
			sax_s9 <= sax_s8;
			cel_s9 <= cel_s8;
			sel_s9 <= sel_s8;
		end
	end

	// Stage 10: projection of all four columns
	logic signed [31:0] v0 [4];
	logic signed [31:0] v1 [4];
	logic signed [31:0] v2 [4];
	logic [3:0][31:0] r0_c, r1_c, r2_c, r3_c;
	logic [3:0][31:0] r0_s10, r1_s10, r2_s10, r3_s10;
	logic [31:0] cx_s10, cy_s10, cz_s10;

	always_comb begin
		v0[0] = -32'(sax_s9);
		v0[1] = 32'(cax_s9);
		v0[2] = '0;
		v0[3] = v03_s9;
		v1[0] = ux_s9;
		v1[1] = uy_s9;
		v1[2] = 32'(cel_s9);
		v1[3] = v13_s9;
		v2[0] = dx_s9;
		v2[1] = dy_s9;
		v2[2] = 32'(sel_s9);
		v2[3] = v23_s9;
		for (int j = 0; j < 4; j++) begin
			r0_c[j] = sat32(mulq(fa, v0[j]));
			r1_c[j] = sat32(mulq(COT_HALF_FOV, v1[j]));
			r2_c[j] = sat32(mulq(PROJ_A, v2[j]) + ((j == 3) ? PROJ_B : 48'sd0));
			r3_c[j] = sat32(-48'(v2[j]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r0_s10 <= r0_c;
			r1_s10 <= r1_c;
			r2_s10 <= r2_c;
			r3_s10 <= r3_c;
			cx_s10 <= sat32(48'(cx_s9));
			cy_s10 <= sat32(48'(cy_s9));
			cz_s10 <= sat32(48'(cz_s9));
		end
	end

	// Column register: hold one item and step through its columns
	logic [3:0][31:0] r0_q, r1_q, r2_q, r3_q;
	logic [31:0] cx_q, cy_q, cz_q;
	logic        ser_load;
	assign ser_load = en && vld_q[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
			ser_col_q   <= '0;
		end else begin
			if (ser_valid_q && !out_stall) begin
				ser_col_q <= ser_col_q + 2'd1;
				if (ser_col_q == 2'd3) begin
					ser_valid_q <= 1'b0;
				end
			end
			if (ser_load) begin
				ser_valid_q <= 1'b1;
				ser_col_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			r0_q <= r0_s10;
			r1_q <= r1_s10;
			r2_q <= r2_s10;
			r3_q <= r3_s10;
			cx_q <= cx_s10;
			cy_q <= cy_s10;
			cz_q <= cz_s10;
		end
	end

	// Drive the result item
	assign out_valid    = ser_valid_q;
	assign column_index = ser_col_q;
	assign row0_value   = r0_q[ser_col_q];
	assign row1_value   = r1_q[ser_col_q];
	assign row2_value   = r2_q[ser_col_q];
	assign row3_value   = r3_q[ser_col_q];
	assign cam_x        = cx_q;
	assign cam_y        = cy_q;
	assign cam_z        = cz_q;
	assign last_column  = ser_col_q == 2'd3;

endmodule
